@@ rtl/ddfi_pkg.sv @@
`default_nettype none

package ddfi_pkg;

  // operation codes carried on func_i
  typedef enum logic [1:0] {
    FUNC_APPEND     = 2'd0,
    FUNC_PUSH_FRONT = 2'd1,
    FUNC_REMOVE     = 2'd2,
    FUNC_PEEK       = 2'd3
  } func_e;

  // result codes carried on status_o
  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_DUP   = 2'd2,
    STATUS_EMPTY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_DONE
  } state_e;

  localparam int unsigned IdW  = 16;
  localparam int unsigned TagW = 32;

endpackage

`default_nettype wire

@@ rtl/ddfi_ram.sv @@
`default_nettype none

module ddfi_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire [WIDTH-1:0]           wdata_i,
  input  wire                       re_i,
  input  wire [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [WIDTH-1:0]          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/dedup_deque_front_insert.sv @@
// append / front insert load the result after a duplicate scan of the queue
//   (one id read per queued entry); a full or empty queue skips the scan
// remove / peek load the result after one front read of the slots; an empty queue skips it
// one operation in flight: the next transfer in is taken in the cycle after the result is
//   loaded, and a result is loaded only when no earlier result is held on a stalled output
// reset clears head, fill count and handshake state; slot memories are not cleared
`default_nettype none

module dedup_deque_front_insert
  import ddfi_pkg::*;
#(
  parameter int unsigned DEPTH = 128
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // request channel
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire [1:0]                       func_i,
  input  wire [IdW-1:0]                   entry_id_i,
  input  wire [TagW-1:0]                  entry_tag_i,
  // result channel
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic [1:0]                      status_o,
  output logic [IdW-1:0]                  out_id_o,
  output logic [TagW-1:0]                 out_tag_o,
  output logic [$clog2(DEPTH+1)-1:0]      occupancy_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW:0]   DepthWide = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] DepthCnt  = CW'(DEPTH);
  localparam logic [AW-1:0] LastSlot  = AW'(DEPTH - 1);

  // physical slot of the entry at a given offset from head, wrapped at DEPTH
  function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW + 1)'(base) + (CW + 1)'(off);
    if (sum >= DepthWide) begin
      sum = sum - DepthWide;
    end
    return sum[AW-1:0];
  endfunction

  state_e state_q, state_d;

  // queue bookkeeping; appends write the slot at head + fill, wrapped at DEPTH
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] fill_q, fill_d;

  // captured request
  func_e          func_q;
  logic [IdW-1:0]  id_q;
  logic [TagW-1:0] tag_q;

  // duplicate scan: issue pointer, read-in-flight flag, sticky match
  logic [CW-1:0] scan_q, scan_d;
  logic          pend_q, pend_d;
  logic          dup_q, dup_d;

  // result register
  logic            out_valid_q, out_valid_d;
  logic [1:0]      status_q, status_d;
  logic [IdW-1:0]  out_id_q, out_id_d;
  logic [TagW-1:0] out_tag_q, out_tag_d;
  logic [CW-1:0]   occ_q, occ_d;

  // memory ports
  logic            id_re, tag_re, wr_en;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [IdW-1:0]  rd_id;
  logic [TagW-1:0] rd_tag;

  logic in_xfer, is_insert_in, is_insert_q, full_q, empty_q, out_free, ld;

  assign in_stall_o   = (state_q != ST_IDLE);
  assign in_xfer      = in_valid_i && !in_stall_o;
  assign is_insert_in = (func_i == FUNC_APPEND) || (func_i == FUNC_PUSH_FRONT);
  assign is_insert_q  = (func_q == FUNC_APPEND) || (func_q == FUNC_PUSH_FRONT);
  assign full_q       = (fill_q == DepthCnt);
  assign empty_q      = (fill_q == '0);
  // the result register can take a new result this cycle
  assign out_free     = !(out_valid_q && out_stall_i);
  assign ld           = (state_q == ST_DONE) && out_free;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (is_insert_in) begin
            // full or empty queue needs no duplicate scan
            state_d = (fill_q == DepthCnt || fill_q == '0) ? ST_DONE : ST_SCAN;
          end else begin
            state_d = (fill_q == '0) ? ST_DONE : ST_READ;
          end
        end
      end
      ST_SCAN: begin
        if (scan_q >= fill_q && !pend_q) begin
          state_d = ST_DONE;
        end
      end
      ST_READ: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    head_d      = head_q;
    fill_d      = fill_q;
    scan_d      = scan_q;
    pend_d      = 1'b0;
    dup_d       = dup_q;
    id_re       = 1'b0;
    tag_re      = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = slot_at(head_q, fill_q);
    rd_addr     = slot_at(head_q, scan_q);
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    out_id_d    = out_id_q;
    out_tag_d   = out_tag_q;
    occ_d       = occ_q;

    unique case (state_q)
      ST_IDLE: begin
        scan_d  = '0;
        dup_d   = 1'b0;
        rd_addr = head_q;
        // front read for remove / peek starts with the transfer in
        if (in_xfer && !is_insert_in && fill_q != '0) begin
          id_re  = 1'b1;
          tag_re = 1'b1;
        end
      end
      ST_SCAN: begin
        if (scan_q < fill_q) begin
          id_re  = 1'b1;
          scan_d = scan_q + 1'b1;
          pend_d = 1'b1;
        end
        if (pend_q && rd_id == id_q) begin
          dup_d = 1'b1;
        end
      end
      ST_READ: ;
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_id_d    = '0;
          out_tag_d   = '0;
          status_d    = STATUS_DONE;
          if (is_insert_q) begin
            if (full_q) begin
              status_d = STATUS_FULL;
            end else if (dup_q) begin
              status_d = STATUS_DUP;
            end else begin
              wr_en  = 1'b1;
              fill_d = fill_q + 1'b1;
              if (func_q == FUNC_PUSH_FRONT) begin
                head_d  = (head_q == '0) ? LastSlot : head_q - 1'b1;
                wr_addr = head_d;
              end
            end
          end else if (empty_q) begin
            status_d = STATUS_EMPTY;
          end else begin
            out_id_d  = rd_id;
            out_tag_d = rd_tag;
            if (func_q == FUNC_REMOVE) begin
              fill_d = fill_q - 1'b1;
              // a drained queue restarts at slot zero
              if (fill_q == CW'(1)) begin
                head_d = '0;
              end else begin
                head_d = (head_q == LastSlot) ? '0 : head_q + 1'b1;
              end
            end
          end
          occ_d = fill_d;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      dup_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      scan_q      <= scan_d;
      pend_q      <= pend_d;
      dup_q       <= dup_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      func_q <= func_e'(func_i);
      id_q   <= entry_id_i;
      tag_q  <= entry_tag_i;
    end
    status_q  <= status_d;
    out_id_q  <= out_id_d;
    out_tag_q <= out_tag_d;
    occ_q     <= occ_d;
  end

  // slot memories share addressing; tags are read only for the front entry
  ddfi_ram #(
    .WIDTH (IdW),
    .DEPTH (DEPTH)
  ) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (id_q),
    .re_i    (id_re),
    .raddr_i (rd_addr),
    .rdata_o (rd_id)
  );

  ddfi_ram #(
    .WIDTH (TagW),
    .DEPTH (DEPTH)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (tag_q),
    .re_i    (tag_re),
    .raddr_i (rd_addr),
    .rdata_o (rd_tag)
  );

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_id_o    = out_id_q;
  assign out_tag_o   = out_tag_q;
  assign occupancy_o = occ_q;

  // occupancy never exceeds the slot count
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= DepthCnt)
    else $error("fill count above depth");

  // an empty queue always has its head at slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni) empty_q |-> head_q == '0)
    else $error("empty queue with nonzero head");

  // slots are written only when a result is produced for an insert
  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_en |-> ld && is_insert_q)
    else $error("slot write outside insert completion");

  // a successful remove drops the fill count by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld && func_q == FUNC_REMOVE && !empty_q |=> fill_q == $past(fill_q) - 1'b1)
    else $error("remove did not shrink queue");

  // a loaded result is never lost while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(status_q) && $stable(occ_q))
    else $error("stalled result changed");

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top
  import ddfi_pkg::*;
();

  localparam int unsigned DEPTH = 128;
  // quiet cycles with no transfer on either channel before the run is declared hung
  localparam int unsigned WATCH_LIMIT = 2000;
  // output hold-off that forces the block to back up and stall its input
  localparam int unsigned FLOOD_HOLD = 400;
  localparam int unsigned FLOOD_AFTER = 300;
  localparam int unsigned TOTAL_OPS = 1550;
  // drain time after the last result, above the longest insert scan
  localparam int unsigned TAIL_CYCLES = 140;

  typedef enum {
    PH_FILL,
    PH_DRAIN,
    PH_MIX
  } phase_e;

  // shadow copy of the queue; predicts each result and checks it on arrival
  class deque_mirror;
    typedef struct {
      status_e   status;
      bit [15:0] id;
      bit [31:0] tag;
      bit [7:0]  occ;
    } reply_t;

    bit [15:0]   slot_id[DEPTH];
    bit [31:0]   slot_tag[DEPTH];
    bit [6:0]    head;
    int unsigned fill;
    reply_t      awaited[$];
    int unsigned faults;

    function bit holds_id(bit [15:0] id);
      for (int unsigned i = 0; i < fill; i++) begin
        if (slot_id[head + 7'(i)] == id) return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit [15:0] queued_id(int unsigned k);
      return slot_id[head + 7'(k)];
    endfunction

    function void take_request(func_e f, bit [15:0] id, bit [31:0] tag);
      reply_t   r;
      bit [6:0] pos;
      r.status = STATUS_DONE;
      r.id     = '0;
      r.tag    = '0;
      if (f == FUNC_APPEND || f == FUNC_PUSH_FRONT) begin
        // full check wins over the duplicate check
        if (fill >= DEPTH) begin
          r.status = STATUS_FULL;
        end else if (holds_id(id)) begin
          r.status = STATUS_DUP;
        end else begin
          if (f == FUNC_APPEND) begin
            pos = head + 7'(fill);
          end else begin
            head = head - 7'd1;
            pos  = head;
          end
          slot_id[pos]  = id;
          slot_tag[pos] = tag;
          fill++;
        end
      end else begin
        if (fill == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.id  = slot_id[head];
          r.tag = slot_tag[head];
          if (f == FUNC_REMOVE) begin
            head = head + 7'd1;
            fill--;
            // an emptied queue restarts at slot zero
            if (fill == 0) head = '0;
          end
        end
      end
      r.occ = 8'(fill);
      awaited.push_back(r);
    endfunction

    function void check_reply(logic [1:0] st, logic [15:0] id, logic [31:0] tag,
                              logic [7:0] occ);
      reply_t r;
      if (awaited.size() == 0) begin
        $error("result transfer with no request pending");
        faults++;
        return;
      end
      r = awaited.pop_front();
      if (st !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, st);
        faults++;
      end
      if (id !== r.id) begin
        $error("out_id: expected %h, got %h", r.id, id);
        faults++;
      end
      if (tag !== r.tag) begin
        $error("out_tag: expected %h, got %h", r.tag, tag);
        faults++;
      end
      if (occ !== r.occ) begin
        $error("occupancy: expected %0d, got %0d", r.occ, occ);
        faults++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  func = FUNC_PEEK;
  logic [15:0] entry_id = '0;
  logic [31:0] entry_tag = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [15:0] out_id;
  logic [31:0] out_tag;
  logic [7:0]  occupancy;

  deque_mirror mirror = new();
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_calm = 0;
  int unsigned recv_calm = 0;
  bit          flood_on = 1'b0;
  bit          flood_done = 1'b0;

  dedup_deque_front_insert #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .func_i     (func),
    .entry_id_i (entry_id),
    .entry_tag_i(entry_tag),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .status_o   (status),
    .out_id_o   (out_id),
    .out_tag_o  (out_tag),
    .occupancy_o(occupancy)
  );

  always #2 clk_i = ~clk_i;

  // random pause before each transfer, with occasional runs of back-to-back traffic
  task automatic draw_pause(inout int unsigned calm, output int unsigned pause);
    if (calm == 0 && $urandom_range(0, 15) == 0) calm = $urandom_range(10, 60);
    if (calm > 0) begin
      calm--;
      pause = 0;
    end else begin
      pause = $urandom_range(0, 18);
    end
  endtask

  // present one request and hold it until the block takes the transfer
  task automatic issue_op(input func_e f, input bit [15:0] id, input bit [31:0] tag);
    int unsigned pause;
    draw_pause(send_calm, pause);
    if (flood_on) pause = 0;
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    func      <= f;
    entry_id  <= id;
    entry_tag <= tag;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    mirror.take_request(f, id, tag);
    items_sent++;
  endtask

  // one random request shaped by the current phase; some ids repeat queued ones
  task automatic random_op(input phase_e ph);
    int unsigned roll;
    int unsigned pick;
    func_e       f;
    bit [15:0]   id;
    bit [31:0]   tag;
    roll = $urandom_range(0, 99);
    case (ph)
      PH_FILL: begin
        f = (roll < 45) ? FUNC_APPEND : (roll < 88) ? FUNC_PUSH_FRONT :
            (roll < 95) ? FUNC_REMOVE : FUNC_PEEK;
      end
      PH_DRAIN: begin
        f = (roll < 10) ? FUNC_APPEND : (roll < 18) ? FUNC_PUSH_FRONT :
            (roll < 85) ? FUNC_REMOVE : FUNC_PEEK;
      end
      default: begin
        f = func_e'($urandom_range(0, 3));
      end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 12 && mirror.fill > 0) begin
      id = mirror.queued_id($urandom_range(0, mirror.fill - 1));
    end else if (pick < 15) begin
      id = 16'h0000;
    end else if (pick < 18) begin
      id = 16'hffff;
    end else begin
      id = 16'($urandom);
    end
    pick = $urandom_range(0, 99);
    tag = (pick < 5) ? 32'h0 : (pick < 10) ? 32'hffff_ffff : $urandom;
    issue_op(f, id, tag);
  endtask

  // request side
  initial begin
    phase_e      ph;
    int unsigned span;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue on both reads
    issue_op(FUNC_PEEK, 16'h1111, 32'h1111_1111);
    issue_op(FUNC_REMOVE, 16'hffff, 32'hffff_ffff);
    // extreme ids and tags
    issue_op(FUNC_APPEND, 16'h0000, 32'h0000_0000);
    issue_op(FUNC_APPEND, 16'hffff, 32'hffff_ffff);
    issue_op(FUNC_PUSH_FRONT, 16'h1234, 32'ha5a5_a5a5);
    // duplicates through either insert
    issue_op(FUNC_APPEND, 16'h0000, 32'h5a5a_5a5a);
    issue_op(FUNC_PUSH_FRONT, 16'hffff, 32'h0f0f_0f0f);
    issue_op(FUNC_PUSH_FRONT, 16'h1234, 32'h0);
    issue_op(FUNC_PEEK, 16'h0, 32'h0);
    // drain to empty so the head returns to slot zero
    issue_op(FUNC_REMOVE, 16'h0, 32'h0);
    issue_op(FUNC_REMOVE, 16'h0, 32'h0);
    issue_op(FUNC_PEEK, 16'h0, 32'h0);
    issue_op(FUNC_REMOVE, 16'h0, 32'h0);
    issue_op(FUNC_REMOVE, 16'h0, 32'h0);
    // front insert from head zero wraps to the top slot
    issue_op(FUNC_PUSH_FRONT, 16'h0007, 32'hdead_beef);
    issue_op(FUNC_APPEND, 16'h0008, 32'h8000_0001);
    issue_op(FUNC_PUSH_FRONT, 16'h0009, 32'h7fff_fffe);
    issue_op(FUNC_PEEK, 16'h0, 32'h0);
    issue_op(FUNC_REMOVE, 16'h0, 32'h0);
    issue_op(FUNC_REMOVE, 16'h0, 32'h0);
    issue_op(FUNC_PEEK, 16'h0, 32'h0);
    issue_op(FUNC_REMOVE, 16'h0, 32'h0);
    issue_op(FUNC_PEEK, 16'h0, 32'h0);

    // first random phase is insert-heavy, to drive the queue to full and keep inserting
    for (int unsigned i = 0; i < 320; i++) random_op(PH_FILL);
    while (items_sent < TOTAL_OPS) begin
      ph   = phase_e'($urandom_range(0, 2));
      span = $urandom_range(40, 250);
      for (int unsigned i = 0; i < span && items_sent < TOTAL_OPS; i++) random_op(ph);
    end
    in_valid <= 1'b0;

    while (mirror.awaited.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mirror.faults == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // result side: random stall before each transfer, one long hold-off to back up the block
  initial begin
    int unsigned pause;
    @(posedge rst_ni);
    forever begin
      draw_pause(recv_calm, pause);
      if (!flood_done && items_sent >= FLOOD_AFTER) begin
        flood_on = 1'b1;
        pause    = FLOOD_HOLD;
      end
      if (pause > 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk_i);
      end
      if (flood_on) begin
        flood_on   = 1'b0;
        flood_done = 1'b1;
      end
      out_stall <= 1'b0;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
      mirror.check_reply(status, out_id, out_tag, occupancy);
    end
  end

  // hang detection: cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule
